>>> hdl/assert_macros.svh
// assertion helpers, clocked on i_clk and quiet while i_rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge outside reset
`define SSLRU_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// implication checked at every rising edge outside reset
`define SSLRU_ASSERT_IMP(label, ante, cons, msg) \
    `SSLRU_ASSERT(label, (ante) |-> (cons), msg)

`endif

>>> hdl/sslru_pkg.sv
package sslru_pkg;

    localparam int SLOTS    = 8;
    localparam int TAG_BITS = 32;
    localparam int STAMP_W  = 64;
    localparam int SLOT_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    typedef enum logic [1:0] {
        FN_ACQUIRE = 2'd0,
        FN_RELEASE = 2'd1,
        FN_FORGET  = 2'd2
    } t_func;

    typedef enum logic [1:0] {
        RS_OK        = 2'd0,
        RS_BUSY      = 2'd1,
        RS_NOT_FOUND = 2'd2,
        RS_IGNORED   = 2'd3
    } t_res_status;

    typedef enum logic [1:0] {
        HOW_TAG  = 2'd0,
        HOW_FREE = 2'd1,
        HOW_LRU  = 2'd2
    } t_how;

    typedef enum logic [1:0] {
        SLOT_FREE = 2'd0,
        SLOT_IDLE = 2'd1,
        SLOT_BUSY = 2'd2
    } t_slot_st;

    typedef struct packed {
        t_slot_st              st;
        logic                  tag_vld;
        logic [TAG_BITS-1:0]   tag;
        logic [STAMP_W-1:0]    stamp;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

>>> hdl/sslru_ram.sv
module sslru_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> hdl/session_slot_lru_allocator_unit.sv
// channel   | dir | fields (lowest bit up)
// ----------+-----+--------------------------------------------------------------
// s (in)    | in  | tuser: func[1:0] has_tag[2]; tdata: session_tag[31:0]
//           |     |   release_slot[34:32] keep[35], zero fill to 40 bits
// m (out)   | out | tdata: status[1:0] granted_slot[4:2] selected_how[6:5], zero [7]
//
// acquire and forget read every slot once through the single table read port,
// then pass through the wait, decide and output states before the next input transfer
// release and unknown operations read one entry, then take the same wait, decide and output states
// reset empties the table at once through per-slot valid bits, no clearing pass
// a finished result waits in the output register while the next item is taken;
// the block stalls only when a new result finds that register still full
`include "assert_macros.svh"

module session_slot_lru_allocator_unit
    import sslru_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [39:0] i_s_tdata,   // session_tag, release_slot, keep, zero fill
    input  logic [2:0]  i_s_tuser,   // func, has_tag
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata    // status, granted_slot, selected_how, zero fill
);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_SCAN   = 6'b000010,
        ST_RD     = 6'b000100,
        ST_WAIT   = 6'b001000,
        ST_DECIDE = 6'b010000,
        ST_OUT    = 6'b100000
    } t_state;

    t_state r_state;

    // request
    logic [1:0]          r_func;
    logic                r_has_tag;
    logic [TAG_BITS-1:0] r_tag;
    logic [2:0]          r_rs;
    logic                r_keep;

    // scan bookkeeping
    logic [SLOT_W-1:0]   r_addr;
    logic                r_rd_vld;
    logic                r_rd_ent_vld;
    logic [SLOT_W-1:0]   r_rd_idx;
    logic [SLOTS-1:0]    r_vld;

    logic                r_m_found;
    logic                r_m_busy;
    logic [SLOT_W-1:0]   r_m_idx;
    logic [STAMP_W-1:0]  r_m_stamp;
    logic                r_f_found;
    logic [SLOT_W-1:0]   r_f_idx;
    logic                r_l_found;
    logic [SLOT_W-1:0]   r_l_idx;
    logic [STAMP_W-1:0]  r_l_stamp;
    t_entry              r_rel_ent;

    logic [STAMP_W-1:0]  r_use_cnt;

    // result
    logic [1:0]          r_res_status;
    logic [2:0]          r_res_granted;
    logic [1:0]          r_res_how;
    logic                r_out_vld;

    // decision
    logic [1:0]          n_status;
    logic [2:0]          n_granted;
    logic [1:0]          n_how;
    logic                n_wr_en;
    logic [SLOT_W-1:0]   n_wr_addr;
    t_entry              n_wr_ent;
    logic                n_cnt_inc;

    logic                s_accept;
    logic                out_free;
    logic                rd_en;
    logic [SLOT_W-1:0]   rd_addr;
    logic [ENTRY_W-1:0]  ram_rdata;
    t_entry              ent;
    logic                rs_in_range;
    logic [STAMP_W-1:0]  cnt_plus;

    assign s_accept   = i_s_tvalid && o_s_tready;
    assign o_s_tready = (r_state == ST_IDLE);
    assign out_free   = !r_out_vld || i_m_tready;
    assign rd_en      = (r_state == ST_SCAN) || (r_state == ST_RD);
    assign rd_addr    = (r_state == ST_RD) ? SLOT_W'(r_rs) : r_addr;

    // an entry never written since reset reads as an empty slot
    assign ent         = r_rd_ent_vld ? t_entry'(ram_rdata) : t_entry'('0);
    assign rs_in_range = 32'(r_rs) < 32'(SLOTS);
    assign cnt_plus    = r_use_cnt + STAMP_W'(1);

    sslru_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(SLOTS)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (n_wr_en),
        .i_wr_addr (n_wr_addr),
        .i_wr_data (n_wr_ent),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (ram_rdata)
    );

    always_comb begin
        n_status  = RS_IGNORED;
        n_granted = '0;
        n_how     = HOW_TAG;
        n_wr_en   = 1'b0;
        n_wr_addr = '0;
        n_wr_ent  = '0;
        n_cnt_inc = 1'b0;
        if (r_state == ST_DECIDE) begin
            case (r_func)
                FN_ACQUIRE: begin
                    n_wr_ent.st      = SLOT_BUSY;
                    n_wr_ent.tag_vld = r_has_tag;
                    n_wr_ent.tag     = r_has_tag ? r_tag : '0;
                    if (r_has_tag && r_m_found && r_m_busy) begin
                        n_status = RS_BUSY;
                    end else if (r_has_tag && r_m_found) begin
                        n_status       = RS_OK;
                        n_how          = HOW_TAG;
                        n_wr_en        = 1'b1;
                        n_wr_addr      = r_m_idx;
                        n_wr_ent.stamp = r_m_stamp;
                    end else if (r_f_found) begin
                        n_status       = RS_OK;
                        n_how          = HOW_FREE;
                        n_wr_en        = 1'b1;
                        n_wr_addr      = r_f_idx;
                        n_wr_ent.stamp = '0;
                    end else if (r_l_found) begin
                        n_status       = RS_OK;
                        n_how          = HOW_LRU;
                        n_wr_en        = 1'b1;
                        n_wr_addr      = r_l_idx;
                        n_wr_ent.stamp = r_l_stamp;
                    end else begin
                        n_status = RS_BUSY;
                    end
                    if (n_wr_en) begin
                        n_granted = 3'(n_wr_addr);
                    end
                end
                FN_RELEASE: begin
                    if (rs_in_range && r_rel_ent.st == SLOT_BUSY) begin
                        n_status  = RS_OK;
                        n_wr_en   = 1'b1;
                        n_wr_addr = SLOT_W'(r_rs);
                        if (r_keep) begin
                            n_cnt_inc        = 1'b1;
                            n_wr_ent         = r_rel_ent;
                            n_wr_ent.st      = SLOT_IDLE;
                            n_wr_ent.stamp   = cnt_plus;
                        end
                    end
                end
                FN_FORGET: begin
                    if (!r_m_found) begin
                        n_status = RS_NOT_FOUND;
                    end else if (r_m_busy) begin
                        n_status = RS_BUSY;
                    end else begin
                        n_status  = RS_OK;
                        n_wr_en   = 1'b1;
                        n_wr_addr = r_m_idx;
                    end
                end
                default: begin
                    n_status = RS_IGNORED;
                end
            endcase
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_vld     <= '0;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_use_cnt <= '0;
            r_addr    <= '0;
        end else begin
            r_rd_vld <= rd_en;
            if (n_wr_en) begin
                r_vld[n_wr_addr] <= 1'b1;
            end
            if (n_cnt_inc) begin
                r_use_cnt <= cnt_plus;
            end
            if (r_out_vld && i_m_tready) begin
                r_out_vld <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    r_addr <= '0;
                    if (s_accept) begin
                        if (i_s_tuser[1:0] == FN_ACQUIRE || i_s_tuser[1:0] == FN_FORGET) begin
                            r_state <= ST_SCAN;
                        end else begin
                            r_state <= ST_RD;
                        end
                    end
                end
                ST_SCAN: begin
                    r_addr <= r_addr + SLOT_W'(1);
                    if (32'(r_addr) == SLOTS - 1) begin
                        r_state <= ST_WAIT;
                    end
                end
                ST_RD: r_state <= ST_WAIT;
                // hold here until the previous result has left the output register
                ST_WAIT: begin
                    if (out_free) begin
                        r_state <= ST_DECIDE;
                    end
                end
                ST_DECIDE: r_state <= ST_OUT;
                ST_OUT: begin
                    if (out_free) begin
                        r_out_vld <= 1'b1;
                        r_state   <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_func    <= i_s_tuser[1:0];
            r_has_tag <= i_s_tuser[2];
            r_tag     <= TAG_BITS'(i_s_tdata[31:0]);
            r_rs      <= i_s_tdata[34:32];
            r_keep    <= i_s_tdata[35];
            r_m_found <= 1'b0;
            r_f_found <= 1'b0;
            r_l_found <= 1'b0;
        end
        r_rd_ent_vld <= r_vld[rd_addr];
        r_rd_idx     <= rd_addr;
        if (r_rd_vld) begin
            r_rel_ent <= ent;
            // first slot carrying the tag
            if (!r_m_found && ent.tag_vld && ent.tag == r_tag) begin
                r_m_found <= 1'b1;
                r_m_idx   <= r_rd_idx;
                r_m_busy  <= (ent.st == SLOT_BUSY);
                r_m_stamp <= ent.stamp;
            end
            if (!r_f_found && ent.st == SLOT_FREE) begin
                r_f_found <= 1'b1;
                r_f_idx   <= r_rd_idx;
            end
            // strict compare keeps the lowest index on equal stamps
            if (ent.st == SLOT_IDLE && (!r_l_found || ent.stamp < r_l_stamp)) begin
                r_l_found <= 1'b1;
                r_l_idx   <= r_rd_idx;
                r_l_stamp <= ent.stamp;
            end
        end
        if (r_state == ST_DECIDE) begin
            r_res_status  <= n_status;
            r_res_granted <= n_granted;
            r_res_how     <= n_how;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {1'b0, r_res_how, r_res_granted, r_res_status};

    `SSLRU_ASSERT_IMP(a_out_from_seq, $rose(o_m_tvalid), $past(r_state == ST_OUT),
        "result appeared without passing the output state")
    `SSLRU_ASSERT_IMP(a_unused_zero, o_m_tvalid && o_m_tdata[1:0] != RS_OK,
        o_m_tdata[6:2] == 5'd0, "slot or choice set on a result that is not ok")
    `SSLRU_ASSERT_IMP(a_busy_after_take, s_accept, ##1 !o_s_tready,
        "input taken again before the table work finished")

endmodule
